// ===== rtl/bcsc_pkg.sv =====
// bcsc_pkg: shared types, stage codes, register indexes and field widths
// for the battery charge stage controller; no dependencies
package bcsc_pkg;

    localparam int LEVEL_W = 12;
    localparam int DUTY_W  = 8;
    localparam int TIME_W  = 32;
    localparam int CLS_W   = 3;
    localparam int STAGE_W = 3;
    localparam int INDEX_W = 3;

    // charge stages
    localparam logic [STAGE_W-1:0] STG_IDLE = 3'd0;
    localparam logic [STAGE_W-1:0] STG_PRE  = 3'd1;
    localparam logic [STAGE_W-1:0] STG_CC   = 3'd2;
    localparam logic [STAGE_W-1:0] STG_RC   = 3'd3;
    localparam logic [STAGE_W-1:0] STG_TERM = 3'd4;

    // temperature classes
    localparam logic [CLS_W-1:0] CLS_NONE = 3'd0;
    localparam logic [CLS_W-1:0] CLS_COLD = 3'd1;
    localparam logic [CLS_W-1:0] CLS_HOT  = 3'd4;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_LOW_CAPACITY  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_PRECHARGE_EXIT = 3'd1;
    localparam logic [INDEX_W-1:0] REG_FULL          = 3'd2;
    localparam logic [INDEX_W-1:0] REG_RECHARGE      = 3'd3;
    localparam logic [INDEX_W-1:0] REG_FAST_RATE     = 3'd4;
    localparam logic [INDEX_W-1:0] REG_HEATER        = 3'd5;
    localparam logic [INDEX_W-1:0] REG_IDLE_TIMEOUT  = 3'd6;
    localparam logic [INDEX_W-1:0] REG_CHECK_DELAY   = 3'd7;

    typedef struct packed {
        logic [LEVEL_W-1:0] low_capacity_level;
        logic [LEVEL_W-1:0] precharge_exit_level;
        logic [LEVEL_W-1:0] full_level;
        logic [LEVEL_W-1:0] recharge_level;
        logic [DUTY_W-1:0]  fast_rate;
        logic               heater_fitted;
        logic [TIME_W-1:0]  idle_timeout_ms;
        logic [TIME_W-1:0]  check_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic [LEVEL_W-1:0] battery_level;
        logic [LEVEL_W-1:0] charger_level;
        logic [CLS_W-1:0]   temp_bottom;
        logic [CLS_W-1:0]   temp_top;
        logic               in_standby;
    } item_t;

    typedef struct packed {
        logic fast;
        logic full;
        logic disconnect;
        logic fail;
    } flags_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  pwm_duty;
        logic [STAGE_W-1:0] stage_now;
        flags_t             leds;
    } result_t;

endpackage

// ===== rtl/bcsc_cfg.sv =====
// bcsc_cfg: configuration register file with reset defaults
// depends on bcsc_pkg
module bcsc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [bcsc_pkg::INDEX_W-1:0]  wr_index,
    input  logic [bcsc_pkg::TIME_W-1:0]   wr_data,
    output bcsc_pkg::cfg_t                cfg
);

    bcsc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_capacity_level   <= 12'd1000;
            cfg_reg.precharge_exit_level <= 12'd2000;
            cfg_reg.full_level           <= 12'd3500;
            cfg_reg.recharge_level       <= 12'd3300;
            cfg_reg.fast_rate            <= 8'd50;
            cfg_reg.heater_fitted        <= 1'b0;
            cfg_reg.idle_timeout_ms      <= 32'd600000;
            cfg_reg.check_delay_ms       <= 32'd1000;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                bcsc_pkg::REG_LOW_CAPACITY:
                    cfg_reg.low_capacity_level <= wr_data[bcsc_pkg::LEVEL_W-1:0];
                bcsc_pkg::REG_PRECHARGE_EXIT:
                    cfg_reg.precharge_exit_level <= wr_data[bcsc_pkg::LEVEL_W-1:0];
                bcsc_pkg::REG_FULL:
                    cfg_reg.full_level <= wr_data[bcsc_pkg::LEVEL_W-1:0];
                bcsc_pkg::REG_RECHARGE:
                    cfg_reg.recharge_level <= wr_data[bcsc_pkg::LEVEL_W-1:0];
                bcsc_pkg::REG_FAST_RATE:
                    cfg_reg.fast_rate <= wr_data[bcsc_pkg::DUTY_W-1:0];
                bcsc_pkg::REG_HEATER:
                    cfg_reg.heater_fitted <= wr_data[0];
                bcsc_pkg::REG_IDLE_TIMEOUT:
                    cfg_reg.idle_timeout_ms <= wr_data;
                bcsc_pkg::REG_CHECK_DELAY:
                    cfg_reg.check_delay_ms <= wr_data;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/bcsc_core.sv =====
// bcsc_core: charge stage state, start time, duty and indicator registers
// with the per-tick update logic; depends on bcsc_pkg
module bcsc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  bcsc_pkg::cfg_t    cfg,
    input  logic              step,
    input  bcsc_pkg::item_t   item,
    output bcsc_pkg::result_t result
);

    logic [bcsc_pkg::STAGE_W-1:0] stage_reg, stage_next;
    logic [bcsc_pkg::TIME_W-1:0]  start_reg, start_next;
    logic [bcsc_pkg::DUTY_W-1:0]  duty_reg, duty_next;
    bcsc_pkg::flags_t             flags_reg, flags_next;

    logic [bcsc_pkg::TIME_W-1:0]  elapsed;
    logic [bcsc_pkg::DUTY_W-1:0]  half_rate;
    logic                         hot;
    logic                         cold;
    logic                         pack_absent;
    logic                         settled;
    logic                         chg_low;

    assign elapsed     = item.now_ms - start_reg;
    assign half_rate   = cfg.fast_rate >> 1;
    assign hot         = (item.temp_bottom >= bcsc_pkg::CLS_HOT)
                         || (item.temp_top >= bcsc_pkg::CLS_HOT);
    assign cold        = (item.temp_bottom == bcsc_pkg::CLS_COLD)
                         || (item.temp_top == bcsc_pkg::CLS_COLD);
    assign pack_absent = (item.temp_bottom == bcsc_pkg::CLS_NONE)
                         && (item.temp_top == bcsc_pkg::CLS_NONE);
    assign settled     = (elapsed >= cfg.check_delay_ms);
    assign chg_low     = (item.charger_level < item.battery_level);

    always_comb
    begin
        stage_next = stage_reg;
        start_next = start_reg;
        duty_next  = duty_reg;
        flags_next = flags_reg;
        if (pack_absent)
        begin
            duty_next             = '0;
            flags_next.fast       = 1'b0;
            flags_next.disconnect = 1'b1;
            stage_next            = bcsc_pkg::STG_IDLE;
        end
        else if (!item.in_standby)
        begin
            duty_next       = '0;
            flags_next.fail = 1'b0;
            flags_next.fast = 1'b0;
            flags_next.full = 1'b0;
            stage_next      = bcsc_pkg::STG_IDLE;
            start_next      = item.now_ms;
        end
        else if (hot || (cfg.heater_fitted && cold))
        begin
            duty_next       = '0;
            flags_next.fast = 1'b0;
            flags_next.full = 1'b0;
            stage_next      = bcsc_pkg::STG_IDLE;
            start_next      = item.now_ms;
        end
        else
        begin
            unique case (stage_reg)
                bcsc_pkg::STG_IDLE:
                begin
                    if (item.battery_level <= cfg.low_capacity_level)
                    begin
                        if (elapsed < cfg.idle_timeout_ms)
                        begin
                            duty_next = half_rate;
                        end
                        else
                        begin
                            duty_next             = '0;
                            flags_next.disconnect = 1'b1;
                        end
                    end
                    else
                    begin
                        duty_next       = half_rate;
                        flags_next.fast = 1'b1;
                        stage_next      = bcsc_pkg::STG_PRE;
                        start_next      = item.now_ms;
                    end
                end
                bcsc_pkg::STG_PRE:
                begin
                    if (item.battery_level >= cfg.precharge_exit_level)
                    begin
                        duty_next       = cfg.fast_rate;
                        flags_next.fast = 1'b1;
                        stage_next      = bcsc_pkg::STG_CC;
                        start_next      = item.now_ms;
                    end
                    else if (item.battery_level < cfg.low_capacity_level)
                    begin
                        duty_next             = '0;
                        flags_next.fast       = 1'b0;
                        flags_next.disconnect = 1'b1;
                        stage_next            = bcsc_pkg::STG_IDLE;
                        start_next            = item.now_ms;
                    end
                    else if (settled)
                    begin
                        flags_next.fail = chg_low;
                    end
                end
                bcsc_pkg::STG_CC:
                begin
                    if (item.battery_level >= cfg.full_level)
                    begin
                        duty_next       = '0;
                        flags_next.fast = 1'b0;
                        flags_next.full = 1'b1;
                        stage_next      = bcsc_pkg::STG_TERM;
                        start_next      = item.now_ms;
                    end
                    else if (settled)
                    begin
                        flags_next.fail = chg_low;
                    end
                end
                bcsc_pkg::STG_RC:
                begin
                    if (item.battery_level >= cfg.full_level)
                    begin
                        duty_next       = '0;
                        flags_next.full = 1'b1;
                        stage_next      = bcsc_pkg::STG_TERM;
                        start_next      = item.now_ms;
                    end
                    else if (item.battery_level <= cfg.recharge_level)
                    begin
                        duty_next       = cfg.fast_rate;
                        flags_next.fast = 1'b1;
                        stage_next      = bcsc_pkg::STG_CC;
                        start_next      = item.now_ms;
                    end
                    else if (settled)
                    begin
                        flags_next.fail = chg_low;
                    end
                end
                bcsc_pkg::STG_TERM:
                begin
                    if (settled && (item.battery_level < cfg.recharge_level))
                    begin
                        duty_next  = half_rate;
                        stage_next = bcsc_pkg::STG_RC;
                    end
                end
                default:
                begin
                    stage_next = bcsc_pkg::STG_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= bcsc_pkg::STG_IDLE;
            start_reg <= '0;
            duty_reg  <= '0;
            flags_reg <= '0;
        end
        else if (step)
        begin
            stage_reg <= stage_next;
            start_reg <= start_next;
            duty_reg  <= duty_next;
            flags_reg <= flags_next;
        end
    end

    assign result.pwm_duty  = duty_next;
    assign result.stage_now = stage_next;
    assign result.leds      = flags_next;

    // stage register only holds defined stages
    a_stage_legal: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg <= bcsc_pkg::STG_TERM)
        else $error("stage register out of range");

    // terminated stage never drives the charger
    a_term_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg == bcsc_pkg::STG_TERM |-> duty_reg == '0)
        else $error("duty nonzero in terminated stage");

    // disconnect indicator is sticky until reset
    a_disc_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(flags_reg.disconnect))
        else $error("disconnect indicator cleared");

    // state moves only on a tick
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(stage_reg) && $stable(start_reg) && $stable(duty_reg))
        else $error("state changed without a tick");

endmodule

// ===== rtl/battery_charge_stage_controller.sv =====
// battery_charge_stage_controller: top level with input register, stage core
// and result register; depends on bcsc_pkg, bcsc_cfg and bcsc_core
//
// A tick is first captured in the input register, then the stage logic (a
// handful of level compares and one 32-bit elapsed-time subtract) updates the
// stage state and loads the result register in the same edge, from which the
// result leaves. Either register frees when the stage after it takes its
// content, so the block sustains one tick per cycle while the result side
// keeps up.
// Configuration writes are always ready and must be made while no tick is in
// flight.
module battery_charge_stage_controller (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // now_ms[31:0], battery_level[43:32], charger_level[55:44],
    // temp_bottom[58:56], temp_top[61:59], in_standby[62], zero[63]
    input  logic [63:0]                  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // pwm_duty[7:0], stage_now[10:8], led_fast[11], led_full[12],
    // led_disconnect[13], led_fail[14], zero[15]
    output logic [15:0]                  m_axis_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bcsc_pkg::INDEX_W-1:0] cfg_index,
    input  logic [bcsc_pkg::TIME_W-1:0]  cfg_data
);

    bcsc_pkg::cfg_t    cfg;
    bcsc_pkg::item_t   in_item_reg;
    bcsc_pkg::result_t result;
    bcsc_pkg::result_t out_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              step;

    assign cfg_ready     = 1'b1;
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    bcsc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bcsc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.now_ms        <= s_axis_tdata[31:0];
            in_item_reg.battery_level <= s_axis_tdata[43:32];
            in_item_reg.charger_level <= s_axis_tdata[55:44];
            in_item_reg.temp_bottom   <= s_axis_tdata[58:56];
            in_item_reg.temp_top      <= s_axis_tdata[61:59];
            in_item_reg.in_standby    <= s_axis_tdata[62];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0,
                            out_reg.leds.fail,
                            out_reg.leds.disconnect,
                            out_reg.leds.full,
                            out_reg.leds.fast,
                            out_reg.stage_now,
                            out_reg.pwm_duty};

    // a held input register means the result side is stalled
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without a stalled result");

    // a pending input always reaches the result register on a free slot
    a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("tick processed but no result pending");

endmodule
